// ===== src/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_REM_TK = 2'd2,
        CMD_REM_T  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Broadcast to every cell
    typedef struct packed {
        logic             fire;
        logic             full;
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } op_t;

    // Flags rippling from head to tail
    typedef struct packed {
        logic ins;
        logic found;
    } chain_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH (key, tag) entries, smallest key at
// the head, equal keys in arrival order. Each slave item carries a command
// in s_tuser and key/tag in s_tdata; every command yields exactly one master
// item with the dequeued entry (if any), a status code and the occupancy
// after the command. All cells compare against the broadcast key/tag and
// shift in parallel at the accept edge, and the result sits in one output
// register, so one command per cycle is accepted as long as m_tready keeps
// that register draining. Reset clears only the count and the output valid flag.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_key[15:0], item_tag[31:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_key[15:0], out_tag[31:16], occupancy[36:32], zero[39:37]
    output logic [2:0]  m_tuser    // out_valid[0], status[2:1]
);

    op_t     op;
    logic    accept;
    count_t  count_reg;
    count_t  count_next;
    logic    m_valid_reg;
    logic    out_valid_reg;
    entry_t  out_entry_reg;
    status_t status_reg;
    count_t  occ_reg;
    status_t status_next;
    logic    out_valid_next;
    entry_t  out_entry_next;

    logic   cell_occ   [DEPTH];
    chain_t cell_chain [DEPTH];
    entry_t cell_entry [DEPTH];
    logic   found_any;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign op.fire = accept;
    assign op.full = (count_reg == CNT_W'(DEPTH));
    assign op.cmd  = cmd_t'(s_tuser);
    assign op.key  = s_tdata[15:0];
    assign op.tag  = s_tdata[31:16];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            chain_t chain_prev;
            entry_t entry_prev;
            entry_t entry_succ;

            assign cell_occ[i] = (count_reg > CNT_W'(i));

            if (i == 0) begin : g_head
                assign chain_prev = '0;
                assign entry_prev = '0;
            end else begin : g_body
                assign chain_prev = cell_chain[i-1];
                assign entry_prev = cell_entry[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                assign entry_succ = '0;
            end else begin : g_mid
                assign entry_succ = cell_entry[i+1];
            end

            spq_cell u_cell (
                .aclk       (aclk),
                .op         (op),
                .occ        (cell_occ[i]),
                .chain_prev (chain_prev),
                .entry_prev (entry_prev),
                .entry_succ (entry_succ),
                .chain_out  (cell_chain[i]),
                .entry_out  (cell_entry[i])
            );
        end
    endgenerate

    assign found_any = cell_chain[DEPTH-1].found;

    always_comb begin
        count_next     = count_reg;
        status_next    = ST_OK;
        out_valid_next = 1'b0;
        out_entry_next = '0;
        unique case (op.cmd) inside
            CMD_ENQ: begin
                if (op.full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_valid_next = 1'b1;
                    out_entry_next = cell_entry[0];
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            CMD_REM_TK, CMD_REM_T: begin
                if (!found_any) begin
                    status_next = ST_NOMATCH;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_valid_reg <= out_valid_next;
            out_entry_reg <= out_entry_next;
            status_reg    <= status_next;
            occ_reg       <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, OCC_W'(occ_reg), out_entry_reg.tag, out_entry_reg.key};
    assign m_tuser  = {status_reg, out_valid_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item gave no result");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_valid_reg |-> status_reg == ST_OK)
        else $error("dequeued entry with bad status");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_valid_reg |-> out_entry_reg == '0)
        else $error("entry fields not zero without dequeue");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op.cmd == CMD_ENQ && !op.full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not grow count");

endmodule

// ===== src/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic   aclk,
    input  op_t    op,
    input  logic   occ,
    input  chain_t chain_prev,
    input  entry_t entry_prev,
    input  entry_t entry_succ,
    output chain_t chain_out,
    output entry_t entry_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    always_comb begin
        unique case (op.cmd)
            CMD_ENQ:    hit = 1'b0;
            CMD_DEQ:    hit = occ;
            CMD_REM_TK: hit = occ && (entry_reg.tag == op.tag) && (entry_reg.key == op.key);
            CMD_REM_T:  hit = occ && (entry_reg.tag == op.tag);
            default:    hit = 1'b0;
        endcase
    end

    assign chain_out.ins   = !occ || (entry_reg.key > op.key);
    assign chain_out.found = chain_prev.found || hit;

    always_comb begin
        entry_next = entry_reg;
        if (op.fire) begin
            if (op.cmd == CMD_ENQ) begin
                if (!op.full && chain_out.ins) begin
                    // shift toward tail, or take the new item at the boundary
                    entry_next = chain_prev.ins ? entry_prev : entry_t'{key: op.key, tag: op.tag};
                end
            end else if (chain_out.found) begin
                // close the gap
                entry_next = entry_succ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule
